### sv/s256bc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s256bc_pkg: shared types, constants and functions
// Word types, the initial hash value, the round constant table and the
// SHA-256 sigma functions used by the block compressor.
// ----------------------------------------------------------------------------
package s256bc_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int POS_W       = $clog2(BLOCK_BYTES);
    localparam int WORD_W      = 32;
    localparam int BLK_WORDS   = BLOCK_BYTES / 4;
    localparam int BLK_BITS    = BLK_WORDS * WORD_W;
    localparam int HASH_WORDS  = 8;
    localparam int ROUNDS      = 64;
    localparam int RND_W       = $clog2(ROUNDS);
    localparam int IDX_W       = $clog2(HASH_WORDS);

    typedef logic [WORD_W-1:0]                 t_word;
    typedef logic [HASH_WORDS-1:0][WORD_W-1:0] t_state;
    typedef logic [BLK_BITS-1:0]               t_block;

    typedef struct packed {
        logic             shift_byte;
        logic             load;
        logic             round;
        logic [RND_W-1:0] rnd;
    } t_core_ctrl;

    localparam t_state INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic t_word round_k(input logic [RND_W-1:0] idx);
        t_word k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage
`default_nettype wire

### sv/s256bc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s256bc_in_if: message byte channel
// Valid/ready channel carrying one message byte and the restart flag per beat.
// ----------------------------------------------------------------------------
interface s256bc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface
`default_nettype wire

### sv/s256bc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s256bc_out_if: hash word channel
// Valid/ready channel carrying one chaining-value word per beat.
// ----------------------------------------------------------------------------
interface s256bc_out_if;
    logic                                valid;
    logic                                ready;
    logic [31:0]                         hash_word;
    logic [s256bc_pkg::IDX_W-1:0]        word_index;
    logic                                last_word;

    modport source (output valid, output hash_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input hash_word, input word_index,
                    input last_word, output ready);
endinterface
`default_nettype wire

### sv/s256bc_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s256bc_round: block buffer, message schedule and round unit
// The 512-bit block register takes bytes by shifting and doubles as the
// 16-word schedule window; one round of the compression runs per cycle.
// ----------------------------------------------------------------------------
module s256bc_round (
    input  wire                      i_clk,
    input  wire s256bc_pkg::t_core_ctrl i_ctrl,
    input  wire  [7:0]               i_byte,
    input  wire s256bc_pkg::t_state  i_chain,
    output s256bc_pkg::t_state       o_vars
);

    localparam int W = s256bc_pkg::WORD_W;
    localparam int B = s256bc_pkg::BLK_BITS;

    s256bc_pkg::t_block r_blk;
    s256bc_pkg::t_state r_v;

    s256bc_pkg::t_word w0, w1, w9, w14, w_new;
    s256bc_pkg::t_word t1, t2, ch, maj;

    // window slot k holds w[t+k]; slot 0 is the top word
    assign w0  = r_blk[B-1      -: W];
    assign w1  = r_blk[B-1-W    -: W];
    assign w9  = r_blk[B-1-9*W  -: W];
    assign w14 = r_blk[B-1-14*W -: W];

    assign w_new = w0 + s256bc_pkg::small_sigma0(w1) + w9 + s256bc_pkg::small_sigma1(w14);

    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + s256bc_pkg::big_sigma1(r_v[4]) + ch
               + s256bc_pkg::round_k(i_ctrl.rnd) + w0;
    assign t2  = s256bc_pkg::big_sigma0(r_v[0]) + maj;

    always_ff @(posedge i_clk) begin
        priority if (i_ctrl.shift_byte) begin
            r_blk <= {r_blk[B-9:0], i_byte};
        end else if (i_ctrl.round) begin
            r_blk <= {r_blk[B-W-1:0], w_new};
        end else begin
            r_blk <= r_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctrl.load) begin
            r_v <= i_chain;
        end else if (i_ctrl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end else begin
            r_v <= r_v;
        end
    end

    assign o_vars = r_v;

endmodule
`default_nettype wire

### sv/sha256_block_compress_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: the byte that completes a block is followed by the 64 rounds,
//   a feed-forward step into the chaining value, then eight output beats.
// Throughput: one byte per cycle while filling; no new byte is accepted while
//   the rounds run or the hash words are streamed out.
// Reset: synchronous active-low; loads the initial hash, clears the byte
//   position and returns the sequencer to idle. Buffer contents are not reset.
// ----------------------------------------------------------------------------
// sha256_block_compress_top: SHA-256 block absorber and compressor
// Packs message bytes into a 64-byte block, runs the 64-round compression on
// a shared round unit and streams out the updated eight-word chaining value.
// ----------------------------------------------------------------------------
module sha256_block_compress_top (
    input  wire               i_clk,
    input  wire               i_rst_n,
    s256bc_in_if.sink         i_byte_ch,
    s256bc_out_if.source      o_hash_ch
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam int POS_W = s256bc_pkg::POS_W;
    localparam int RND_W = s256bc_pkg::RND_W;
    localparam int IDX_W = s256bc_pkg::IDX_W;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(s256bc_pkg::BLOCK_BYTES - 1);
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(s256bc_pkg::ROUNDS - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(s256bc_pkg::HASH_WORDS - 1);

    logic [1:0]         r_state, n_state;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [RND_W-1:0]   r_rnd, n_rnd;
    logic [IDX_W-1:0]   r_idx, n_idx;
    s256bc_pkg::t_state r_chain;

    logic               in_beat, out_beat, blk_done;
    logic [POS_W-1:0]   pos_eff;
    s256bc_pkg::t_state vars;
    s256bc_pkg::t_core_ctrl ctrl;

    assign i_byte_ch.ready = (r_state == ST_IDLE);
    assign in_beat         = i_byte_ch.valid && i_byte_ch.ready;
    assign out_beat        = o_hash_ch.valid && o_hash_ch.ready;
    assign pos_eff         = i_byte_ch.restart ? '0 : r_pos;
    assign blk_done        = in_beat && (pos_eff == POS_LAST);

    assign ctrl.shift_byte = in_beat;
    assign ctrl.load       = blk_done;
    assign ctrl.round      = (r_state == ST_ROUND);
    assign ctrl.rnd        = r_rnd;

    s256bc_round u_round (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl),
        .i_byte  (i_byte_ch.data_byte),
        .i_chain (r_chain),
        .o_vars  (vars)
    );

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_rnd   = r_rnd;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_pos = pos_eff + 1'b1;
                    n_rnd = '0;
                    if (blk_done) begin
                        n_state = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                n_rnd = r_rnd + 1'b1;
                if (r_rnd == RND_LAST) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                n_idx   = '0;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_beat) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == IDX_LAST) begin
                        n_state = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_rnd   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_rnd   <= n_rnd;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= s256bc_pkg::INIT_HASH;
        end else if (in_beat && i_byte_ch.restart) begin
            r_chain <= s256bc_pkg::INIT_HASH;
        end else if (r_state == ST_FINAL) begin
            for (int k = 0; k < s256bc_pkg::HASH_WORDS; k++) begin
                r_chain[k] <= r_chain[k] + vars[k];
            end
        end
    end

    assign o_hash_ch.valid      = (r_state == ST_OUT);
    assign o_hash_ch.hash_word  = r_chain[r_idx];
    assign o_hash_ch.word_index = r_idx;
    assign o_hash_ch.last_word  = (r_idx == IDX_LAST);

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_byte_ch.ready && o_hash_ch.valid))
        else $error("input ready while output beat pending");

    a_block_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blk_done |=> (r_state == ST_ROUND) && (r_rnd == '0))
        else $error("completed block did not start rounds at round zero");

    a_rounds_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) && (r_rnd == RND_LAST) |=> (r_state == ST_FINAL))
        else $error("round sequence did not end after last round");

    a_last_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && o_hash_ch.last_word |=> (r_state == ST_IDLE) && i_byte_ch.ready)
        else $error("not idle after last hash word");

    a_final_to_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINAL) |=> o_hash_ch.valid && (o_hash_ch.word_index == '0))
        else $error("output run did not start at word zero");
`endif

endmodule
`default_nettype wire
